### rtl/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg
// Types and codes shared by the bounded recent item list and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package brl_pkg;

    localparam int ACT_W  = 3;
    localparam int TIME_W = 32;
    localparam int ID_W   = 63;
    localparam int POS_W  = 6;
    localparam int STAT_W = 4;
    localparam int CNT_W  = 6;

    // request action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TRUNC  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

    // response status codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 4'd0;
    localparam logic [STAT_W-1:0] ST_TAIL_DROP = 4'd1;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 4'd2;
    localparam logic [STAT_W-1:0] ST_FULL_OLD  = 4'd3;
    localparam logic [STAT_W-1:0] ST_DELETED   = 4'd4;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 4'd5;
    localparam logic [STAT_W-1:0] ST_DONE      = 4'd6;
    localparam logic [STAT_W-1:0] ST_READ_OK   = 4'd7;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 4'd8;

    typedef enum logic [0:0] {
        S_IDLE,
        S_WALK
    } t_state;

    typedef struct packed {
        logic signed [TIME_W-1:0] ts;
        logic [ID_W-1:0]          ident;
    } t_entry;

endpackage

`default_nettype wire

### rtl/brl_if.sv
// ----------------------------------------------------------------------------
// brl_if
// Request and response channels of the bounded recent item list.
// ----------------------------------------------------------------------------
`default_nettype none

interface brl_req_if import brl_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [TIME_W-1:0] item_time;
    logic [ID_W-1:0]          item_id;
    logic [POS_W-1:0]         position;

    modport source (output valid, output action, output item_time, output item_id,
                    output position, input ready);
    modport sink   (input valid, input action, input item_time, input item_id,
                    input position, output ready);
endinterface

interface brl_rsp_if import brl_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         entry_count;
    logic signed [TIME_W-1:0] read_time;
    logic [ID_W-1:0]          read_id;

    modport source (output valid, output status, output entry_count, output read_time,
                    output read_id, input ready);
    modport sink   (input valid, input status, input entry_count, input read_time,
                    input read_id, output ready);
endinterface

`default_nettype wire

### rtl/bounded_recent_item_list.sv
// ----------------------------------------------------------------------------
// bounded_recent_item_list
// Newest-first list of (time, id) entries held in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  i_req    | in  | valid/ready   | action, item_time, item_id, position
//  o_rsp    | out | valid/ready   | status, entry_count, read_time, read_id
//
//  One request at a time. Read, truncate, clear and unused actions do not
//  walk the memory; insert and delete walk it one entry per cycle (read
//  port one entry ahead of the entry being examined).
//  Reset empties the list at once; no memory clearing pass is needed.
//  A stalled response sits in the output register with one more in a
//  pending stage; a new request is taken once the pending stage is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_recent_item_list import brl_pkg::*; #(
    parameter int MAX_ENTRIES = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    brl_req_if.sink    i_req,
    brl_rsp_if.source  o_rsp
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    t_entry mem [MAX_ENTRIES];

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_used, n_used;
    logic [CW-1:0]            r_idx, n_idx;
    logic                     r_shift, n_shift;
    t_entry                   r_carry, n_carry;
    t_entry                   r_rd;
    logic [ACT_W-1:0]         r_act;
    logic signed [TIME_W-1:0] r_time;
    logic [ID_W-1:0]          r_id;
    logic [POS_W-1:0]         r_pos;

    logic                     r_pend_valid;
    logic [STAT_W-1:0]        r_pend_status;
    logic [CNT_W-1:0]         r_pend_cnt;
    t_entry                   r_pend_data;

    logic                     r_out_valid;
    logic [STAT_W-1:0]        r_out_status;
    logic [CNT_W-1:0]         r_out_cnt;
    t_entry                   r_out_data;

    logic                     w_accept;
    logic                     w_done;
    logic [STAT_W-1:0]        w_status;
    t_entry                   w_rdata;
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    t_entry                   w_wdata;
    logic [AW-1:0]            w_raddr;
    logic [CW-1:0]            w_idx_nx;
    logic [CW-1:0]            w_idx_pv;
    logic [CW-1:0]            w_last;
    logic                     w_at_end;
    logic                     w_room;
    logic [XW-1:0]            w_pos_x;
    logic [XW-1:0]            w_used_x;
    logic [XW-1:0]            w_ipos_x;
    logic                     w_load_out;
    t_entry                   w_new;

    assign i_req.ready = (r_state == S_IDLE) && !r_pend_valid;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_idx_nx = r_idx + 1'b1;
    assign w_idx_pv = r_idx - 1'b1;
    assign w_room   = (r_used < MAX_C);
    assign w_last   = w_room ? r_used : (MAX_C - 1'b1);
    assign w_at_end = (r_idx == r_used);
    assign w_pos_x  = XW'(r_pos);
    assign w_used_x = XW'(r_used);
    assign w_ipos_x = XW'(i_req.position);
    assign w_new    = '{ts: r_time, ident: r_id};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_WALK;
            end
            S_WALK: begin
                if (w_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // walk datapath and memory port control
    always_comb begin
        n_used   = r_used;
        n_idx    = r_idx;
        n_shift  = r_shift;
        n_carry  = r_carry;
        w_done   = 1'b0;
        w_status = ST_DONE;
        w_rdata  = '0;
        w_we     = 1'b0;
        w_waddr  = r_idx[AW-1:0];
        w_wdata  = w_new;
        w_raddr  = '0;

        case (r_state)
            S_IDLE: begin
                n_idx   = '0;
                n_shift = 1'b0;
                if (i_req.action == ACT_READ && w_ipos_x < XW'(MAX_C)) begin
                    w_raddr = AW'(i_req.position);
                end
            end
            S_WALK: begin
                // read one entry ahead of the one being examined
                if (w_idx_nx < MAX_C) w_raddr = w_idx_nx[AW-1:0];
                case (r_act)
                    ACT_INSERT: begin
                        if (!r_shift) begin
                            if (w_at_end) begin
                                w_done = 1'b1;
                                if (w_room) begin
                                    w_we     = 1'b1;
                                    n_used   = r_used + 1'b1;
                                    w_status = ST_INSERTED;
                                end else begin
                                    w_status = ST_FULL_OLD;
                                end
                            end else if (r_rd.ident == r_id) begin
                                w_done   = 1'b1;
                                w_status = ST_DUPLICATE;
                            end else if ($signed(r_time) >= $signed(r_rd.ts)) begin
                                w_we    = 1'b1;
                                n_carry = r_rd;
                                if (r_idx == w_last) begin
                                    // list full and place is the tail: drop it
                                    w_done   = 1'b1;
                                    w_status = ST_TAIL_DROP;
                                end else begin
                                    n_shift = 1'b1;
                                    n_idx   = w_idx_nx;
                                end
                            end else begin
                                n_idx = w_idx_nx;
                            end
                        end else begin
                            // push the carried entry down one place
                            w_we    = 1'b1;
                            w_wdata = r_carry;
                            n_carry = r_rd;
                            if (r_idx == w_last) begin
                                w_done = 1'b1;
                                if (w_room) begin
                                    n_used   = r_used + 1'b1;
                                    w_status = ST_INSERTED;
                                end else begin
                                    w_status = ST_TAIL_DROP;
                                end
                            end else begin
                                n_idx = w_idx_nx;
                            end
                        end
                    end
                    ACT_DELETE: begin
                        if (!r_shift) begin
                            if (w_at_end) begin
                                w_done   = 1'b1;
                                w_status = ST_NOT_FOUND;
                            end else begin
                                if (r_rd.ident == r_id) n_shift = 1'b1;
                                n_idx = w_idx_nx;
                            end
                        end else begin
                            if (w_at_end) begin
                                w_done   = 1'b1;
                                n_used   = r_used - 1'b1;
                                w_status = ST_DELETED;
                            end else begin
                                // pull this entry up one place
                                w_we    = 1'b1;
                                w_waddr = w_idx_pv[AW-1:0];
                                w_wdata = r_rd;
                                n_idx   = w_idx_nx;
                            end
                        end
                    end
                    ACT_TRUNC: begin
                        w_done = 1'b1;
                        if (w_used_x > w_pos_x) n_used = CW'(r_pos);
                    end
                    ACT_CLEAR: begin
                        w_done = 1'b1;
                        n_used = '0;
                    end
                    ACT_READ: begin
                        w_done = 1'b1;
                        if (w_pos_x < w_used_x) begin
                            w_status = ST_READ_OK;
                            w_rdata  = r_rd;
                        end else begin
                            w_status = ST_BAD_INDEX;
                        end
                    end
                    default: begin
                        w_done = 1'b1;
                    end
                endcase
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rd <= mem[w_raddr];
    end

    assign w_load_out = r_pend_valid && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (r_state == S_WALK && w_done) begin
                r_pend_valid <= 1'b1;
            end else if (w_load_out) begin
                r_pend_valid <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_shift <= n_shift;
        r_carry <= n_carry;
        if (w_accept) begin
            r_act  <= i_req.action;
            r_time <= i_req.item_time;
            r_id   <= i_req.item_id;
            r_pos  <= i_req.position;
        end
        if (r_state == S_WALK && w_done) begin
            r_pend_status <= w_status;
            r_pend_cnt    <= CNT_W'(n_used);
            r_pend_data   <= w_rdata;
        end
        if (w_load_out) begin
            r_out_status <= r_pend_status;
            r_out_cnt    <= r_pend_cnt;
            r_out_data   <= r_pend_data;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_cnt;
    assign o_rsp.read_time   = r_out_data.ts;
    assign o_rsp.read_id     = r_out_data.ident;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= MAX_C)
        else $error("entry count beyond capacity");

    a_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_state == S_WALK)
        else $error("memory write outside a walk");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK && r_act == ACT_INSERT |=> r_used >= $past(r_used))
        else $error("insert reduced the entry count");

    a_pend_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid && (!r_out_valid || o_rsp.ready) |=> !r_pend_valid)
        else $error("pending response not moved to output");
`endif

endmodule

`default_nettype wire

### tb/bounded_recent_item_list_tb.sv
// ----------------------------------------------------------------------------
// bounded_recent_item_list_tb
// Self-checking bench for the newest-first bounded item list. A scoreboard
// class keeps its own copy of the list, works out the response to every
// accepted request and matches it against the response channel in order.
// Directed requests hit the edges first; random runs with fill bursts follow
// under four handshake idling phases.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_recent_item_list_tb;
    import brl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = 32;
    localparam int ITEMS_PER_PH = 275;
    localparam int SETTLE_CYC   = LIST_DEPTH + 8;

    // action codes the block does not use; they answer done
    localparam logic [ACT_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

    localparam logic signed [TIME_W-1:0] TIME_MAX = 32'sh7fff_ffff;
    localparam logic signed [TIME_W-1:0] TIME_MIN = 32'sh8000_0000;
    localparam logic [ID_W-1:0]          ID_MAX   = {ID_W{1'b1}};

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         count;
        logic signed [TIME_W-1:0] rtime;
        logic [ID_W-1:0]          rid;
    } t_list_rsp;

    class recent_list_scoreboard;
        logic signed [TIME_W-1:0] ent_time[LIST_DEPTH];
        logic [ID_W-1:0]          ent_id[LIST_DEPTH];
        int unsigned              n_used;
        t_list_rsp                awaited[$];
        int                       errors;
        int                       n_requests;
        int                       status_seen[16];

        function void clear_state();
            n_used     = 0;
            errors     = 0;
            n_requests = 0;
            awaited.delete();
            foreach (status_seen[s]) status_seen[s] = 0;
        endfunction

        function logic [ID_W-1:0] live_id();
            return ent_id[$urandom_range(0, n_used - 1)];
        endfunction

        function logic [STAT_W-1:0] insert_item(logic signed [TIME_W-1:0] t,
                                                logic [ID_W-1:0] id);
            int unsigned last;
            for (int i = 0; i < n_used; i++) begin
                if (ent_id[i] == id) return ST_DUPLICATE;
                if (t >= ent_time[i]) begin
                    last = (n_used < LIST_DEPTH) ? n_used : LIST_DEPTH - 1;
                    for (int k = last; k > i; k--) begin
                        ent_time[k] = ent_time[k-1];
                        ent_id[k]   = ent_id[k-1];
                    end
                    ent_time[i] = t;
                    ent_id[i]   = id;
                    if (n_used < LIST_DEPTH) begin
                        n_used++;
                        return ST_INSERTED;
                    end
                    return ST_TAIL_DROP;
                end
            end
            if (n_used < LIST_DEPTH) begin
                ent_time[n_used] = t;
                ent_id[n_used]   = id;
                n_used++;
                return ST_INSERTED;
            end
            return ST_FULL_OLD;
        endfunction

        function logic [STAT_W-1:0] delete_item(logic [ID_W-1:0] id);
            for (int i = 0; i < n_used; i++) begin
                if (ent_id[i] == id) begin
                    for (int k = i; k + 1 < n_used; k++) begin
                        ent_time[k] = ent_time[k+1];
                        ent_id[k]   = ent_id[k+1];
                    end
                    n_used--;
                    return ST_DELETED;
                end
            end
            return ST_NOT_FOUND;
        endfunction

        function void note_request(logic [ACT_W-1:0] act, logic signed [TIME_W-1:0] t,
                                   logic [ID_W-1:0] id, logic [POS_W-1:0] pos);
            t_list_rsp r;
            r = '0;
            case (act)
                ACT_INSERT: r.status = insert_item(t, id);
                ACT_DELETE: r.status = delete_item(id);
                ACT_TRUNC: begin
                    if (n_used > pos) n_used = pos;
                    r.status = ST_DONE;
                end
                ACT_CLEAR: begin
                    n_used   = 0;
                    r.status = ST_DONE;
                end
                ACT_READ: begin
                    if (pos < n_used) begin
                        r.rtime  = ent_time[pos];
                        r.rid    = ent_id[pos];
                        r.status = ST_READ_OK;
                    end else begin
                        r.status = ST_BAD_INDEX;
                    end
                end
                default: r.status = ST_DONE;
            endcase
            r.count = n_used[CNT_W-1:0];
            awaited = {awaited, r};
            n_requests++;
        endfunction

        function void check_response(t_list_rsp got);
            t_list_rsp exp;
            if (awaited.size() == 0) begin
                $error("unexpected response: status %0d count %0d", got.status, got.count);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            status_seen[got.status]++;
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.count !== exp.count) begin
                $error("entry_count: expected %0d, actual %0d", exp.count, got.count);
                errors++;
            end
            if (got.rtime !== exp.rtime) begin
                $error("read_time: expected %0d, actual %0d", exp.rtime, got.rtime);
                errors++;
            end
            if (got.rid !== exp.rid) begin
                $error("read_id: expected %0h, actual %0h", exp.rid, got.rid);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   rsp_stall_pct;

    recent_list_scoreboard list_sb;

    brl_req_if req_ch ();
    brl_rsp_if rsp_ch ();

    bounded_recent_item_list #(
        .MAX_ENTRIES(LIST_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[bounded_recent_item_list] ERROR");
        $finish;
    end

    // response side: random back-pressure, check every accepted response
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            list_sb.check_response('{rsp_ch.status, rsp_ch.entry_count,
                                     rsp_ch.read_time, rsp_ch.read_id});
        end
        rsp_ch.ready <= (int'($urandom_range(99)) >= rsp_stall_pct);
    end

    task automatic send_request(logic [ACT_W-1:0] act, logic signed [TIME_W-1:0] t,
                                logic [ID_W-1:0] id, logic [POS_W-1:0] pos);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.item_time <= t;
        req_ch.item_id   <= id;
        req_ch.position  <= pos;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        list_sb.note_request(act, t, id, pos);
    endtask

    // hold the request side until every awaited response has come back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (list_sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(9))
            0:       return ID_W'({$urandom, $urandom});
            1:       return ID_MAX;
            2:       return '0;
            default: return ID_W'($urandom_range(1, 48));
        endcase
    endfunction

    function automatic logic signed [TIME_W-1:0] pick_time();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return TIME_MAX;
            2:       return TIME_MIN;
            default: return int'($urandom_range(0, 400)) - 200;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        if ($urandom_range(4) == 0) return POS_W'($urandom_range(0, 63));
        return POS_W'($urandom_range(0, LIST_DEPTH + 1));
    endfunction

    task automatic run_random(int n_items);
        int unsigned sent;
        int unsigned burst;
        int unsigned pick;
        logic [ID_W-1:0] id;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                // fill burst: push the list towards full and past it
                burst = $urandom_range(20, 40);
                for (int b = 0; b < burst; b++) begin
                    send_request(ACT_INSERT, pick_time(), pick_id(), pick_pos());
                end
                sent += burst;
            end else begin
                pick = $urandom_range(99);
                id   = pick_id();
                if (pick < 55) begin
                    send_request(ACT_INSERT, pick_time(), id, pick_pos());
                end else if (pick < 68) begin
                    if (list_sb.n_used != 0 && $urandom_range(9) < 7) id = list_sb.live_id();
                    send_request(ACT_DELETE, pick_time(), id, pick_pos());
                end else if (pick < 88) begin
                    send_request(ACT_READ, pick_time(), id, pick_pos());
                end else if (pick < 94) begin
                    send_request(ACT_TRUNC, pick_time(), id, pick_pos());
                end else if (pick < 96) begin
                    send_request(ACT_CLEAR, pick_time(), id, pick_pos());
                end else begin
                    send_request(ACT_SPARE_5 + 3'($urandom_range(0, 2)), pick_time(), id,
                                 pick_pos());
                end
                sent++;
            end
        end
    endtask

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 82, 0, 36};
        stall_tab = '{0, 0, 82, 36};
        list_sb = new();
        list_sb.clear_state();
        send_idle_pct  = 0;
        rsp_stall_pct  = 0;
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.action    <= ACT_INSERT;
        req_ch.item_time <= '0;
        req_ch.item_id   <= '0;
        req_ch.position  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // edges of the fields and every action on a short list
        send_request(ACT_READ,    '0,       '0,     6'd0);
        send_request(ACT_DELETE,  '0,       63'd5,  6'd0);
        send_request(ACT_INSERT,  TIME_MAX, ID_MAX, 6'd0);
        send_request(ACT_INSERT,  TIME_MIN, '0,     6'd63);
        send_request(ACT_INSERT,  '0,       63'd1,  6'd0);
        send_request(ACT_INSERT,  '0,       63'd2,  6'd0);
        // the older copy of id 1 lies behind the insert point, so no reject
        send_request(ACT_INSERT,  32'sd100, 63'd1,  6'd0);
        send_request(ACT_INSERT,  -32'sd5,  ID_MAX, 6'd0);
        send_request(ACT_READ,    '0,       '0,     6'd1);
        send_request(ACT_READ,    '0,       '0,     6'd4);
        send_request(ACT_READ,    '0,       '0,     6'd63);
        send_request(ACT_DELETE,  '0,       63'd1,  6'd0);
        send_request(ACT_READ,    '0,       '0,     6'd1);
        send_request(ACT_TRUNC,   '0,       '0,     6'd40);
        send_request(ACT_TRUNC,   '0,       '0,     6'd2);
        send_request(ACT_READ,    '0,       '0,     6'd2);
        send_request(ACT_SPARE_5, TIME_MAX, ID_MAX, 6'd63);
        send_request(ACT_SPARE_6, '0,       '0,     6'd0);
        send_request(ACT_SPARE_7, '0,       '0,     6'd0);
        send_request(ACT_CLEAR,   '0,       '0,     6'd0);
        send_request(ACT_READ,    '0,       '0,     6'd0);
        send_request(ACT_TRUNC,   '0,       '0,     6'd0);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_tab[ph];
            rsp_stall_pct = stall_tab[ph];
            run_random(ITEMS_PER_PH / 2);
            drain_responses();
            run_random(ITEMS_PER_PH - ITEMS_PER_PH / 2);
        end

        drain_responses();
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (list_sb.awaited.size() != 0) begin
            $error("%0d responses never arrived", list_sb.awaited.size());
            list_sb.errors++;
        end
        $display("covered %0d requests over four idling phases: %0d inserts, %0d tail drops,",
                 list_sb.n_requests, list_sb.status_seen[ST_INSERTED],
                 list_sb.status_seen[ST_TAIL_DROP]);
        $display("  %0d full rejects, %0d duplicates, %0d deletes, %0d reads ok",
                 list_sb.status_seen[ST_FULL_OLD], list_sb.status_seen[ST_DUPLICATE],
                 list_sb.status_seen[ST_DELETED], list_sb.status_seen[ST_READ_OK]);
        if (list_sb.errors == 0) begin
            $display("[bounded_recent_item_list] OK");
        end else begin
            $display("[bounded_recent_item_list] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
